// ----- sv/text_line_folder_macros.svh -----
// ----------------------------------------------------------------------------
// Text line folder assertion macros
// Shared assertion forms for the line folder modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_FOLDER_MACROS_SVH
`define TEXT_LINE_FOLDER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tlf_pkg.sv -----
// ----------------------------------------------------------------------------
// Text line folder package
// Constants, character codes and shared types of the line folder.
// ----------------------------------------------------------------------------
package tlf_pkg;

    parameter int MAX_LINE_DEF = 40;

    localparam int CHAR_W     = 8;
    localparam int LINE_LEN_W = 6;
    localparam int TAB_W      = 5;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 6'd40;
    localparam logic [TAB_W-1:0]      TAB_RESET      = 5'd4;
    localparam logic [LINE_LEN_W-1:0] LINE_LEN_MIN   = 6'd2;
    localparam logic [TAB_W-1:0]      TAB_MIN        = 5'd1;
    localparam logic [TAB_W-1:0]      TAB_MAX        = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH   = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NL_PRE,
        ST_WORD,
        ST_NL_MID,
        ST_TAIL,
        ST_TAIL2,
        ST_KEEP_RD,
        ST_KEEP_WR,
        ST_NEW_WR
    } tlf_state_t;

    typedef enum logic [1:0] {
        KIND_FLUSH,
        KIND_BLANK,
        KIND_NEWLINE,
        KIND_BREAK
    } tlf_kind_t;

    // Request from the sequencer to the output stage
    typedef struct packed {
        logic              push_const;
        logic              push_read;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } tlf_out_req_t;

    // Room reported by the output stage
    typedef struct packed {
        logic const_ok;
        logic read_ok;
        logic pend_clear;
    } tlf_out_credit_t;

endpackage

// ----- sv/tlf_ram.sv -----
// ----------------------------------------------------------------------------
// Line folder RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 41
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tlf_out.sv -----
// ----------------------------------------------------------------------------
// Line folder output stage
// Result register fed by constants or by RAM read data once the register is free.
// ----------------------------------------------------------------------------
module tlf_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlf_pkg::tlf_out_req_t         req,
    output tlf_pkg::tlf_out_credit_t      credit,
    input  logic [tlf_pkg::CHAR_W-1:0]    rdata,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tlf_pkg::CHAR_W-1:0]    char_out,
    output logic                          last
);
    import tlf_pkg::*;

    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_free;
    logic              load_pend;

    always_comb
    begin
        out_free          = !valid_reg || !result_stall;
        load_pend         = pend_reg && out_free;
        credit.const_ok   = !pend_reg && out_free;
        credit.read_ok    = !pend_reg || out_free;
        credit.pend_clear = !pend_reg;

        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load_pend)
        begin
            valid_next = 1'b1;
            char_next  = rdata;
            last_next  = pend_last_reg;
        end
        else if (req.push_const)
        begin
            valid_next = 1'b1;
            char_next  = req.ch;
            last_next  = req.last;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end

        // Track the read in flight; its data waits in the RAM output
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        if (req.push_read)
        begin
            pend_next      = 1'b1;
            pend_last_next = req.last;
        end
        else if (load_pend)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        pend_last_reg <= pend_last_next;
    end

    assign result_valid = valid_reg;
    assign char_out     = char_reg;
    assign last         = last_reg;

`include "text_line_folder_macros.svh"

    `TLF_ASSERT_IMP(a_const_room, clk, rst_n, req.push_const, credit.const_ok, "constant pushed without room")
    `TLF_ASSERT_IMP(a_read_room, clk, rst_n, req.push_read, credit.read_ok, "read issued over pending data")
    `TLF_ASSERT_NXT(a_pend_hold, clk, rst_n, (pend_reg && !out_free), pend_reg, "pending read data dropped")

endmodule

// ----- sv/tlf_seq.sv -----
// ----------------------------------------------------------------------------
// Line folder sequencer
// Decodes each item, keeps word and column counts, drives the word RAM.
// ----------------------------------------------------------------------------
module tlf_seq #(
    parameter int MAX_LINE = tlf_pkg::MAX_LINE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [tlf_pkg::CHAR_W-1:0]        char_in,
    input  logic                              flush,
    input  logic [tlf_pkg::LINE_LEN_W-1:0]    line_length,
    input  logic [tlf_pkg::TAB_W-1:0]         tab_width,
    output tlf_pkg::tlf_out_req_t             req,
    input  tlf_pkg::tlf_out_credit_t          credit,
    output logic                              ram_we,
    output logic [$clog2(MAX_LINE+1)-1:0]     ram_waddr,
    output logic [tlf_pkg::CHAR_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(MAX_LINE+1)-1:0]     ram_raddr,
    input  logic [tlf_pkg::CHAR_W-1:0]        ram_rdata
);
    import tlf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE + 1);
    localparam int COL_W  = $clog2(MAX_LINE + 17);
    localparam int SUM_W  = COL_W + 1;

    tlf_state_t        state_reg, state_next;
    tlf_kind_t         kind_reg, kind_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              nl2_reg, nl2_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] wc_reg, wc_next;
    logic [COL_W-1:0]  col_reg, col_next;

    logic [LINE_LEN_W-1:0] lim;
    logic [TAB_W-1:0]      ws;
    logic [SUM_W-1:0]      lim_s;
    logic [SUM_W-1:0]      sum1;
    logic [SUM_W-1:0]      sum2;
    logic                  nl1;
    logic                  nl2;
    logic [COL_W-1:0]      col1;
    logic [COL_W-1:0]      col2;
    logic                  accept;
    logic                  is_blank;
    logic [ADDR_W-1:0]     idx_inc;
    tlf_state_t            after_word;

    always_comb
    begin
        // Clamp the fold column and the tab width
        if (line_length < LINE_LEN_MIN)
            lim = LINE_LEN_MIN;
        else if (line_length > LINE_LEN_W'(MAX_LINE))
            lim = LINE_LEN_W'(MAX_LINE);
        else
            lim = line_length;

        if (tab_width < TAB_MIN)
            ws = TAB_MIN;
        else if (tab_width > TAB_MAX)
            ws = TAB_MAX;
        else
            ws = tab_width;

        if (char_in == CH_TAB)
            ws = ws;
        else
            ws = TAB_MIN;

        lim_s = SUM_W'(lim);
        sum1  = SUM_W'(col_reg) + SUM_W'(wc_reg);
        nl1   = sum1 > lim_s;
        col1  = nl1 ? COL_W'(wc_reg) : sum1[COL_W-1:0];
        sum2  = SUM_W'(col1) + SUM_W'(ws);
        nl2   = sum2 > lim_s;
        col2  = nl2 ? COL_W'(ws) : sum2[COL_W-1:0];

        is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
        accept   = item_valid && (state_reg == ST_IDLE);
        idx_inc  = idx_reg + ADDR_W'(1);

        case (kind_reg)
            KIND_FLUSH: after_word = ST_IDLE;
            KIND_BLANK: after_word = nl2_reg ? ST_NL_MID : ST_TAIL;
            default:    after_word = ST_TAIL;
        endcase

        state_next = state_reg;
        kind_next  = kind_reg;
        char_next  = char_reg;
        nl2_next   = nl2_reg;
        end_next   = end_reg;
        idx_next   = idx_reg;
        wc_next    = wc_reg;
        col_next   = col_reg;

        req        = '0;
        ram_we     = 1'b0;
        ram_waddr  = wc_reg;
        ram_wdata  = char_in;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    char_next = char_in;
                    idx_next  = '0;
                    end_next  = wc_reg;
                    if (flush)
                    begin
                        if (wc_reg != '0)
                        begin
                            kind_next  = KIND_FLUSH;
                            col_next   = col1;
                            wc_next    = '0;
                            state_next = nl1 ? ST_NL_PRE : ST_WORD;
                        end
                    end
                    else if (is_blank)
                    begin
                        kind_next  = KIND_BLANK;
                        nl2_next   = nl2;
                        col_next   = col2;
                        wc_next    = '0;
                        state_next = nl1 ? ST_NL_PRE : ST_WORD;
                    end
                    else if (char_in == CH_NL)
                    begin
                        kind_next  = KIND_NEWLINE;
                        col_next   = '0;
                        wc_next    = '0;
                        state_next = nl1 ? ST_NL_PRE : ST_WORD;
                    end
                    else if (SUM_W'(wc_reg) >= lim_s)
                    begin
                        // Break the word; the last stored character is kept
                        kind_next  = KIND_BREAK;
                        end_next   = wc_reg - ADDR_W'(1);
                        col_next   = '0;
                        wc_next    = ADDR_W'(2);
                        state_next = ST_WORD;
                    end
                    else
                    begin
                        ram_we  = 1'b1;
                        wc_next = wc_reg + ADDR_W'(1);
                    end
                end
            end

            ST_NL_PRE:
            begin
                if (credit.const_ok)
                begin
                    req.push_const = 1'b1;
                    req.ch         = CH_NL;
                    state_next     = ST_WORD;
                end
            end

            ST_WORD:
            begin
                if (idx_reg == end_reg)
                begin
                    state_next = after_word;
                end
                else if (credit.read_ok)
                begin
                    req.push_read = 1'b1;
                    req.last      = (kind_reg == KIND_FLUSH) && (idx_inc == end_reg);
                    ram_re        = 1'b1;
                    idx_next      = idx_inc;
                    if (idx_inc == end_reg)
                        state_next = after_word;
                end
            end

            ST_NL_MID:
            begin
                if (credit.const_ok)
                begin
                    req.push_const = 1'b1;
                    req.ch         = CH_NL;
                    state_next     = ST_TAIL;
                end
            end

            ST_TAIL:
            begin
                if (credit.const_ok)
                begin
                    req.push_const = 1'b1;
                    case (kind_reg)
                        KIND_NEWLINE:
                        begin
                            req.ch     = CH_NL;
                            req.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        KIND_BREAK:
                        begin
                            req.ch     = CH_HYPHEN;
                            state_next = ST_TAIL2;
                        end
                        default:
                        begin
                            req.ch     = char_reg;
                            req.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TAIL2:
            begin
                if (credit.const_ok)
                begin
                    req.push_const = 1'b1;
                    req.ch         = CH_NL;
                    req.last       = 1'b1;
                    state_next     = ST_KEEP_RD;
                end
            end

            ST_KEEP_RD:
            begin
                // Wait until the RAM output no longer holds result data
                if (credit.pend_clear)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = end_reg;
                    state_next = ST_KEEP_WR;
                end
            end

            ST_KEEP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = ram_rdata;
                state_next = ST_NEW_WR;
            end

            ST_NEW_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(1);
                ram_wdata  = char_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_FLUSH;
            wc_reg    <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            wc_reg    <= wc_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        nl2_reg  <= nl2_next;
        end_reg  <= end_next;
        idx_reg  <= idx_next;
    end

    assign item_stall = (state_reg != ST_IDLE);

`include "text_line_folder_macros.svh"

    `TLF_ASSERT_IMP(a_wc_bound, clk, rst_n, 1'b1, (wc_reg <= ADDR_W'(MAX_LINE)), "word count past store size")
    `TLF_ASSERT_IMP(a_col_bound, clk, rst_n, 1'b1, (col_reg <= COL_W'(MAX_LINE + 16)), "column past widest line")
    `TLF_ASSERT_IMP(a_one_push, clk, rst_n, req.push_read, (!req.push_const && state_reg == ST_WORD), "read outside word drain")

endmodule

// ----- sv/text_line_folder.sv -----
// ----------------------------------------------------------------------------
// Text line folder
// Greedy word-wrap line folder, one character item in, a run of characters out.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_stall carry char_in and flush. An item is
// taken on a rising edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall carry char_out and last; last
// marks the final character caused by one input item.
// Configuration: cfg_we writes cfg_data into line_length (index 0) or
// tab_width (index 1); write only while the block is idle.
// Throughput: an ordinary character enters the word RAM and gives no result.
// A blank, newline or flush drains the word at one character per cycle through
// the RAM read port while the output is not stalled. A flush gives the word; a
// blank or a newline gives the word and then the blank or a newline, with a
// newline placed ahead of or behind the word where it would pass the fold. A
// forced word break gives the word without its last character, a hyphen and a
// newline; the kept character is read back and rewritten at the front.
// Stall: a stalled result holds in the output register; at most one RAM read
// waits behind it, then the sequencer holds and item_stall stays high.
// Reset: word and column counts clear, line_length returns to 40 and
// tab_width to 4. The word RAM is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module text_line_folder #(
    parameter int MAX_LINE = tlf_pkg::MAX_LINE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [tlf_pkg::CHAR_W-1:0]        char_in,
    input  logic                              flush,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [tlf_pkg::CHAR_W-1:0]        char_out,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [tlf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tlf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE + 1);

    logic [LINE_LEN_W-1:0] line_length_reg;
    logic [TAB_W-1:0]      tab_width_reg;

    tlf_out_req_t      req;
    tlf_out_credit_t   credit;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    // Configuration registers: take the low bits of the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LEN_RESET;
            tab_width_reg   <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_LENGTH: line_length_reg <= cfg_data[LINE_LEN_W-1:0];
                REG_TAB_WIDTH:   tab_width_reg   <= cfg_data[TAB_W-1:0];
                default:         line_length_reg <= line_length_reg;
            endcase
        end
    end

    // Sequencer: decode the item, update counts, issue RAM accesses
    tlf_seq #(
        .MAX_LINE (MAX_LINE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .char_in     (char_in),
        .flush       (flush),
        .line_length (line_length_reg),
        .tab_width   (tab_width_reg),
        .req         (req),
        .credit      (credit),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Word store: one entry more than the longest line
    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LINE + 1)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: hold the result while stalled
    tlf_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .credit       (credit),
        .rdata        (ram_rdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_out     (char_out),
        .last         (last)
    );

endmodule
